>>> hdl/ppm_pkg.sv
package ppm_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 4;
  localparam int CAL_W     = ADC_BITS + 1;             // calibrated extremes
  localparam int LVL_W     = ADC_BITS + FRAC_BITS;     // level shifted by frac bits
  localparam int NUM_W     = ADC_BITS + LVL_W;         // |x - low| * level magnitude
  localparam int N_W       = NUM_W + 1;                // signed normalized value
  localparam int TOUT_W    = 14 + FRAC_BITS;           // signed throttle output
  localparam int CNT_W     = $clog2(NUM_W);

  localparam logic [CAL_W-1:0]    CAL_MAX  = {CAL_W{1'b1}};
  localparam logic [ADC_BITS-1:0] ADC_MAX  = {ADC_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_CAL     = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_PROCESS = 2'd2,
    ACT_SHUT    = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    REG_NORM_MAX   = 3'd0,
    REG_MARGIN     = 3'd1,
    REG_ERR_TIME   = 3'd2,
    REG_DEV_LIMIT  = 3'd3,
    REG_BRAKE_ON   = 3'd4,
    REG_TB_HIGH    = 3'd5,
    REG_TB_LOW     = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_e;

  localparam int E_PLAUS  = 0;
  localparam int E_RANGE  = 1;
  localparam int E_OUTPUT = 2;
  localparam int E_BRANGE = 3;
  localparam int E_BPLAUS = 4;

  typedef struct packed {
    logic [11:0] norm_max;
    logic [9:0]  limit_margin;
    logic [15:0] error_time_ms;
    logic [11:0] deviation_limit;
    logic [11:0] brake_on_level;
    logic [11:0] throttle_brake_high;
    logic [11:0] throttle_brake_low;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       div_start;
    logic       store_n;
    logic       avg;
    logic       eval;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       shut;
    logic       div_done;
  } sts_t;

  typedef struct packed {
    logic [4:0]          error_flags;
    logic                shutdown_latched;
    logic [ADC_BITS-1:0] drive_value;
    logic                drive_write;
  } res_t;

endpackage

>>> hdl/ppm_div.sv
module ppm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppm_pkg::NUM_W-1:0] dividend_i,
  input  logic [ppm_pkg::CAL_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ppm_pkg::NUM_W-1:0] quot_o
);
  import ppm_pkg::*;

  logic [CAL_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [CAL_W:0]   trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = CAL_W'(trial - {1'b0, den_q});
      quo_d = {quo_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[CAL_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hdl/ppm_dp.sv
module ppm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppm_pkg::cmd_t                cmd_i,
  input  ppm_pkg::cfg_t                cfg_i,
  input  logic [1:0]                   action_i,
  input  logic [ppm_pkg::ADC_BITS-1:0] throttle_a_i,
  input  logic [ppm_pkg::ADC_BITS-1:0] throttle_b_i,
  input  logic [ppm_pkg::ADC_BITS-1:0] brake_raw_i,
  input  logic [ppm_pkg::ADC_BITS-1:0] feedback_raw_i,
  input  logic [31:0]                  now_ms_i,
  output ppm_pkg::sts_t                sts_o,
  output ppm_pkg::res_t                res_o
);
  import ppm_pkg::*;

  localparam int PROD_W = CAL_W + 1 + LVL_W + 1;
  localparam int SUM_W  = N_W + 1;
  localparam int T_W    = SUM_W + 1;

  // item latch
  logic [1:0]          act_q;
  logic [ADC_BITS-1:0] raw_q [3];
  logic [ADC_BITS-1:0] fb_q;
  logic [31:0]         now_q;

  // architectural state
  logic [CAL_W-1:0]        hi_q [3], hi_d [3];
  logic [CAL_W-1:0]        lo_q [3], lo_d [3];
  logic signed [TOUT_W-1:0] tout_q, tout_d;
  logic [4:0]              err_q, err_d;
  logic [31:0]             start_q [4], start_d [4];
  logic                    shut_q, shut_d;

  // normalization
  logic signed [N_W-1:0] n_q [3];
  logic [NUM_W-1:0]      num_q;
  logic [CAL_W-1:0]      den_q;
  logic                  neg_q, zero_q;
  logic                  div_done;
  logic [NUM_W-1:0]      quot;

  logic [LVL_W-1:0]        lvl_nm;
  logic signed [CAL_W:0]   diff, span;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]       prod_mag;
  logic [CAL_W-1:0]        span_mag;
  logic signed [SUM_W-1:0] nsum, nhalf;
  logic signed [T_W-1:0]   t_full;

  assign lvl_nm = {cfg_i.norm_max, FRAC_BITS'(0)};

  always_comb begin
    diff     = $signed({2'b0, raw_q[cmd_i.ch]}) - $signed({1'b0, lo_q[cmd_i.ch]});
    span     = $signed({1'b0, hi_q[cmd_i.ch]}) - $signed({1'b0, lo_q[cmd_i.ch]});
    prod     = PROD_W'(diff) * $signed({1'b0, lvl_nm});
    prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    span_mag = span[CAL_W] ? CAL_W'(-span) : CAL_W'(span);
  end

  ppm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // average of the two throttle channels, inverted and saturated
  always_comb begin
    nsum   = SUM_W'(n_q[0]) + SUM_W'(n_q[1]);
    nhalf  = (nsum + $signed(SUM_W'(nsum[SUM_W-1]))) >>> 1;
    t_full = $signed(T_W'(lvl_nm)) - T_W'(nhalf);
  end

  // item evaluation
  logic                    to_fail;
  logic signed [SUM_W-1:0] dn, adn;
  logic [LVL_W-1:0]        lvl_dev;
  logic signed [CAL_W-1:0] br_hi;
  logic signed [TOUT_W:0]  od, aod;
  logic                    dw;
  logic [ADC_BITS-1:0]     dv;
  logic [CAL_W:0]          hsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_d[i] = hi_q[i];
      lo_d[i] = lo_q[i];
    end
    for (int b = 0; b < 4; b++) start_d[b] = start_q[b];
    tout_d  = tout_q;
    err_d   = err_q;
    shut_d  = shut_q;
    dw      = 1'b0;
    dv      = '0;
    to_fail = 1'b0;
    hsum    = '0;
    lvl_dev = {cfg_i.deviation_limit, FRAC_BITS'(0)};
    dn      = SUM_W'(n_q[0]) - SUM_W'(n_q[1]);
    adn     = dn[SUM_W-1] ? -dn : dn;
    br_hi   = $signed({1'b0, cfg_i.norm_max}) - $signed(CAL_W'(cfg_i.limit_margin));
    od      = (TOUT_W+1)'(tout_q) - $signed({2'b0, fb_q, FRAC_BITS'(0)});
    aod     = od[TOUT_W] ? -od : od;

    if (cmd_i.avg) begin
      if (t_full > $signed(T_W'({1'b0, {(TOUT_W-1){1'b1}}})))
        tout_d = {1'b0, {(TOUT_W-1){1'b1}}};
      else if (t_full < T_W'($signed({1'b1, {(TOUT_W-1){1'b0}}})))
        tout_d = {1'b1, {(TOUT_W-1){1'b0}}};
      else
        tout_d = TOUT_W'(t_full);
    end

    if (cmd_i.eval) begin
      case (act_q)
        ACT_CAL: begin
          for (int i = 0; i < 3; i++) begin
            if (CAL_W'(raw_q[i]) > hi_q[i]) hi_d[i] = CAL_W'(raw_q[i]);
            if (CAL_W'(raw_q[i]) < lo_q[i]) lo_d[i] = CAL_W'(raw_q[i]);
          end
        end
        ACT_FINISH: begin
          for (int i = 0; i < 2; i++) begin
            hsum    = {1'b0, hi_q[i]} + (CAL_W+1)'(cfg_i.limit_margin);
            hi_d[i] = hsum[CAL_W] ? CAL_MAX : hsum[CAL_W-1:0];
          end
          tout_d = $signed(TOUT_W'({fb_q, FRAC_BITS'(0)}));
        end
        ACT_SHUT: shut_d = 1'b1;
        ACT_PROCESS: begin
          if (shut_q) begin
            dw = 1'b1;
          end else begin
            for (int b = 0; b < 4; b++)
              if (err_q[b] && (now_q - start_q[b]) > {16'b0, cfg_i.error_time_ms})
                to_fail = 1'b1;
            if (to_fail) begin
              shut_d = 1'b1;
            end else if (adn > $signed(SUM_W'(lvl_dev))) begin
              if (!err_q[E_PLAUS]) begin
                err_d[E_PLAUS]   = 1'b1;
                start_d[E_PLAUS] = now_q;
              end
            end else begin
              err_d[E_PLAUS]   = 1'b0;
              start_d[E_PLAUS] = '0;
              if (raw_q[0] > cfg_i.norm_max || raw_q[1] > cfg_i.norm_max) begin
                if (!err_q[E_RANGE]) begin
                  err_d[E_RANGE]   = 1'b1;
                  start_d[E_RANGE] = now_q;
                end
              end else begin
                err_d[E_RANGE]   = 1'b0;
                start_d[E_RANGE] = '0;
                if ($signed({1'b0, raw_q[2]}) > br_hi ||
                    raw_q[2] < ADC_BITS'(cfg_i.limit_margin)) begin
                  if (!err_q[E_BRANGE]) begin
                    err_d[E_BRANGE]   = 1'b1;
                    start_d[E_BRANGE] = now_q;
                  end
                end else begin
                  err_d[E_BRANGE]   = 1'b0;
                  start_d[E_BRANGE] = '0;
                  dw = 1'b1;
                  if (n_q[2] > $signed(N_W'({cfg_i.brake_on_level, FRAC_BITS'(0)}))) begin
                    if (tout_q > $signed(TOUT_W'({cfg_i.throttle_brake_high,
                                                  FRAC_BITS'(0)}))) begin
                      err_d[E_BPLAUS] = 1'b1;
                      dw = 1'b0;
                    end else if (tout_q < $signed(TOUT_W'({cfg_i.throttle_brake_low,
                                                           FRAC_BITS'(0)}))) begin
                      err_d[E_BPLAUS] = 1'b0;
                    end
                  end else begin
                    err_d[E_BPLAUS] = 1'b0;
                  end
                  if (dw) begin
                    // integer part, saturated
                    if (tout_q[TOUT_W-1])
                      dv = '0;
                    else if ((tout_q >>> FRAC_BITS) > $signed(TOUT_W'(ADC_MAX)))
                      dv = ADC_MAX;
                    else
                      dv = ADC_BITS'(tout_q >>> FRAC_BITS);
                    if (aod > $signed((TOUT_W+1)'(lvl_dev))) begin
                      if (!err_q[E_OUTPUT]) begin
                        err_d[E_OUTPUT]   = 1'b1;
                        start_d[E_OUTPUT] = now_q;
                      end
                    end else begin
                      err_d[E_OUTPUT]   = 1'b0;
                      start_d[E_OUTPUT] = '0;
                    end
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      raw_q[0] <= throttle_a_i;
      raw_q[1] <= throttle_b_i;
      raw_q[2] <= brake_raw_i;
      fb_q     <= feedback_raw_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.mul) begin
      num_q  <= prod_mag[NUM_W-1:0];
      den_q  <= span_mag;
      neg_q  <= prod[PROD_W-1] ^ span[CAL_W];
      zero_q <= (span == '0);
    end
    if (cmd_i.store_n) begin
      if (zero_q)     n_q[cmd_i.ch] <= '0;
      else if (neg_q) n_q[cmd_i.ch] <= -$signed({1'b0, quot});
      else            n_q[cmd_i.ch] <= $signed({1'b0, quot});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        hi_q[i] <= '0;
        lo_q[i] <= CAL_W'(ADC_MAX);
      end
      for (int b = 0; b < 4; b++) start_q[b] <= '0;
      tout_q <= '0;
      err_q  <= '0;
      shut_q <= 1'b0;
    end else begin
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      start_q <= start_d;
      tout_q  <= tout_d;
      err_q   <= err_d;
      shut_q  <= shut_d;
    end
  end

  assign sts_o.action   = act_q;
  assign sts_o.shut     = shut_q;
  assign sts_o.div_done = div_done;

  assign res_o.drive_write      = dw;
  assign res_o.drive_value      = dv;
  assign res_o.shutdown_latched = shut_d;
  assign res_o.error_flags      = err_d;

endmodule

>>> hdl/ppm_ctrl.sv
module ppm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  input  ppm_pkg::sts_t sts_i,
  output ppm_pkg::cmd_t cmd_o
);
  import ppm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_MUL, S_DIV_GO, S_DIV_WAIT, S_AVG, S_EVAL
  } state_e;

  state_e     state_q;
  logic [1:0] ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_DISP;
        S_DISP: begin
          ch_q <= '0;
          if (sts_i.action == ACT_PROCESS && !sts_i.shut) state_q <= S_MUL;
          else state_q <= S_EVAL;
        end
        S_MUL:      state_q <= S_DIV_GO;
        S_DIV_GO:   state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            if (ch_q == 2'd2) begin
              state_q <= S_AVG;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_AVG:      state_q <= S_EVAL;
        S_EVAL:     if (out_free_i) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.ch        = ch_q;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul       = (state_q == S_MUL);
    cmd_o.div_start = (state_q == S_DIV_GO);
    cmd_o.store_n   = (state_q == S_DIV_WAIT) && sts_i.div_done;
    cmd_o.avg       = (state_q == S_AVG);
    cmd_o.eval      = (state_q == S_EVAL) && out_free_i;
  end

endmodule

>>> hdl/pedal_plausibility_monitor.sv
// process item: dispatch, three normalizations of multiply, divider start, 28 divide steps
// and handoff, then average and check; calibrate, finish, shutdown and process-while-shut-down
// items go from dispatch straight to the check
// flow: next beat is taken the cycle after the result is registered, so only one item is
// worked on at a time, and the check waits while the output stalls
// reset: rst_ni async active low; clears calibration, errors, timers and shutdown, loads defaults
module pedal_plausibility_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // throttle_a, throttle_b, brake_raw, feedback_raw, now_ms
  input  logic [79:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_write, drive_value, shutdown_latched, error_flags, zero fill
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppm_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic out_free;
  logic m_valid_q;
  res_t m_res_q;
  reg_e widx;

  // configuration registers
  assign pready = 1'b1;
  assign widx   = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.norm_max            <= 12'd1023;
      cfg_q.limit_margin        <= 10'd20;
      cfg_q.error_time_ms       <= 16'd100;
      cfg_q.deviation_limit     <= 12'd102;
      cfg_q.brake_on_level      <= 12'd102;
      cfg_q.throttle_brake_high <= 12'd256;
      cfg_q.throttle_brake_low  <= 12'd51;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_NORM_MAX:  cfg_q.norm_max            <= pwdata[11:0];
        REG_MARGIN:    cfg_q.limit_margin        <= pwdata[9:0];
        REG_ERR_TIME:  cfg_q.error_time_ms       <= pwdata[15:0];
        REG_DEV_LIMIT: cfg_q.deviation_limit     <= pwdata[11:0];
        REG_BRAKE_ON:  cfg_q.brake_on_level      <= pwdata[11:0];
        REG_TB_HIGH:   cfg_q.throttle_brake_high <= pwdata[11:0];
        REG_TB_LOW:    cfg_q.throttle_brake_low  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (widx)
      REG_NORM_MAX:  prdata = 32'(cfg_q.norm_max);
      REG_MARGIN:    prdata = 32'(cfg_q.limit_margin);
      REG_ERR_TIME:  prdata = 32'(cfg_q.error_time_ms);
      REG_DEV_LIMIT: prdata = 32'(cfg_q.deviation_limit);
      REG_BRAKE_ON:  prdata = 32'(cfg_q.brake_on_level);
      REG_TB_HIGH:   prdata = 32'(cfg_q.throttle_brake_high);
      REG_TB_LOW:    prdata = 32'(cfg_q.throttle_brake_low);
      default:       prdata = '0;
    endcase
  end

  // output register frees up on the same cycle its beat is taken
  assign out_free = !m_valid_q || m_axis_tready;

  ppm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg_q),
    .action_i       (s_axis_tuser),
    .throttle_a_i   (s_axis_tdata[11:0]),
    .throttle_b_i   (s_axis_tdata[23:12]),
    .brake_raw_i    (s_axis_tdata[35:24]),
    .feedback_raw_i (s_axis_tdata[47:36]),
    .now_ms_i       (s_axis_tdata[79:48]),
    .sts_o          (sts),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.eval) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.eval) m_res_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_res_q};

  // one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul, cmd.div_start, cmd.store_n, cmd.avg, cmd.eval}))
    else $error("more than one datapath command");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> (!m_valid_q || m_axis_tready))
    else $error("result overwritten");

  // once an input beat is taken the block is busy in the next cycle
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after accepted beat");

  // a drive while shut down is always zero
  a_shut_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_res_q.drive_write && m_res_q.shutdown_latched)
      |-> (m_res_q.drive_value == '0))
    else $error("nonzero drive while shut down");

endmodule
